// ----- hw/rtl/rlpg_pkg.sv -----
package rlpg_pkg;

  localparam int NUM_LEDS_DEFAULT = 16;
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

  localparam int CFG_ADDR_W = 4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WAIT   = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  // Values of the mode register.
  localparam logic [1:0] MODE_INTERVAL = 2'd0;
  localparam logic [1:0] MODE_DEADLINE = 2'd1;
  localparam logic [1:0] MODE_SINGLE   = 2'd2;

  localparam logic [1:0] MODE_RESET        = 2'd0;
  localparam logic [7:0] WAIT_RESET        = 8'd20;
  localparam logic [15:0] LOOP_PERIOD_RESET = 16'd256;

  typedef enum logic [1:0] {
    CMD_STEP   = 2'd0,
    CMD_SPREAD = 2'd1,
    CMD_SINGLE = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] phase;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  wait_ms;
    logic [15:0] loop_period;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Three-segment color wheel on the reversed position.
  function automatic rgb_t wheel(input logic [7:0] pos);
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] t;
    rgb_t c;
    p = 8'hff - pos;
    if (p < 8'd85) begin
      q = p;
    end else if (p < 8'd170) begin
      q = p - 8'd85;
    end else begin
      q = p - 8'd170;
    end
    t = 8'((q << 1) + q);
    if (p < 8'd85) begin
      c.red = 8'hff - t;
      c.green = 8'd0;
      c.blue = t;
    end else if (p < 8'd170) begin
      c.red = 8'd0;
      c.green = t;
      c.blue = 8'hff - t;
    end else begin
      c.red = t;
      c.green = 8'hff - t;
      c.blue = 8'd0;
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/rlpg_front.sv -----
module rlpg_front
  import rlpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        tick,
  input  logic [31:0] now_ms,
  output logic        cmd_push,
  output cmd_t        cmd_data
);

  logic [31:0] time_mark;
  logic [7:0]  hue_phase;
  logic [8:0]  loop_count;

  logic [31:0] elapsed;
  logic [8:0]  count_inc;
  logic        fire;
  logic        hit_interval;
  logic        hit_deadline;
  logic        hit_single;
  logic [7:0]  phase_inc;

  assign elapsed = now_ms - time_mark;
  assign count_inc = loop_count + 9'd1;
  assign phase_inc = hue_phase + 8'd1;

  assign hit_interval = elapsed >= {24'd0, cfg.wait_ms};
  assign hit_deadline = now_ms > time_mark;
  assign hit_single = {count_inc, 8'h00} >= {1'b0, cfg.loop_period};

  always_comb begin
    fire = 1'b0;
    cmd_data.kind = CMD_STEP;
    unique case (cfg.mode)
      MODE_INTERVAL: begin
        fire = hit_interval;
        cmd_data.kind = CMD_STEP;
      end
      MODE_DEADLINE: begin
        fire = hit_deadline;
        cmd_data.kind = CMD_SPREAD;
      end
      MODE_SINGLE: begin
        fire = hit_single;
        cmd_data.kind = CMD_SINGLE;
      end
      default: begin
        fire = 1'b0;
      end
    endcase
  end

  assign cmd_data.phase = phase_inc;
  assign cmd_push = tick & fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_mark <= 32'd0;
      hue_phase <= 8'd0;
      loop_count <= 9'd0;
    end else if (tick) begin
      if (fire) begin
        hue_phase <= phase_inc;
      end
      unique case (cfg.mode)
        MODE_INTERVAL: begin
          if (hit_interval) begin
            time_mark <= now_ms;
          end
        end
        MODE_DEADLINE: begin
          if (hit_deadline) begin
            time_mark <= now_ms + {24'd0, cfg.wait_ms};
          end
        end
        MODE_SINGLE: begin
          loop_count <= hit_single ? 9'd0 : count_inc;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/rlpg_cmd_fifo.sv -----
module rlpg_cmd_fifo
  import rlpg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  input  logic pop,
  output cmd_t rdata,
  output logic valid,
  output logic full
);

  cmd_t slots [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_PTR_W:0]   count;
  logic do_push;
  logic do_pop;

  assign full = count == (CMD_PTR_W + 1)'(CMD_DEPTH);
  assign valid = count != '0;
  assign do_push = push & ~full;
  assign do_pop = pop & valid;
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/rlpg_back.sv -----
module rlpg_back
  import rlpg_pkg::*;
#(
  parameter int NUM_LEDS = NUM_LEDS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  input  logic       pop,
  output logic       empty,
  output logic [5:0] led_index,
  output logic [7:0] green,
  output logic [7:0] red,
  output logic [7:0] blue,
  output logic       frame_last
);

  localparam int STEP_Q = 256 / NUM_LEDS;
  localparam int STEP_R = 256 % NUM_LEDS;
  localparam logic [5:0] LAST_IDX = 6'(NUM_LEDS - 1);

  logic       busy;
  cmd_kind_t  kind;
  logic [7:0] phase;
  logic [5:0] idx;
  // Running quotient and remainder of idx*256/NUM_LEDS.
  logic [8:0] quo;
  logic [6:0] rem;

  logic       out_valid;
  logic       out_free;
  logic       advance;
  logic       is_last;
  logic       start;
  logic [7:0] pos;
  logic [6:0] rem_sum;
  rgb_t       color;

  assign out_free = ~out_valid | pop;
  assign advance = busy & out_free;
  assign is_last = (kind == CMD_SINGLE) | (idx == LAST_IDX);
  assign start = cmd_valid & (~busy | (advance & is_last));
  assign cmd_pop = start;
  assign empty = ~out_valid;
  assign rem_sum = rem + 7'(STEP_R);

  always_comb begin
    unique case (kind)
      CMD_STEP:   pos = {2'b00, idx} + phase;
      CMD_SPREAD: pos = quo[7:0] + phase;
      CMD_SINGLE: pos = phase;
      default:    pos = phase;
    endcase
  end

  assign color = wheel(pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end else if (advance && is_last) begin
        busy <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      kind <= cmd.kind;
      phase <= cmd.phase;
      idx <= 6'd0;
      quo <= 9'd0;
      rem <= 7'd0;
    end else if (advance) begin
      idx <= idx + 6'd1;
      if (rem_sum >= 7'(NUM_LEDS)) begin
        rem <= rem_sum - 7'(NUM_LEDS);
        quo <= quo + 9'(STEP_Q + 1);
      end else begin
        rem <= rem_sum;
        quo <= quo + 9'(STEP_Q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_index <= (kind == CMD_SINGLE) ? 6'd0 : idx;
      green <= color.green;
      red <= color.red;
      blue <= color.blue;
      frame_last <= is_last;
    end
  end

endmodule

// ----- hw/rtl/rainbow_led_pattern_generator.sv -----
// Rainbow LED generator. Each pushed beat is a millisecond tick; depending on
// the mode it may start an update that yields one color beat per LED (modes 0
// and 1, NUM_LEDS beats) or a single beat for LED 0 (mode 2), each tagged with
// its LED index and frame_last on the final beat. A tick is taken in every
// cycle while the four-entry update queue between the tick decoder and the
// LED sequencer has room; the sequencer then drives one LED result a cycle
// while the results are popped. Mode 3 ignores ticks. Registers must be
// written over the APB port only while no update is pending or being
// delivered; the block itself does not enforce this.
module rainbow_led_pattern_generator
  import rlpg_pkg::*;
#(
  parameter int NUM_LEDS = NUM_LEDS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  push,
  output logic                  full,
  input  logic [31:0]           now_ms,
  output logic                  empty,
  input  logic                  pop,
  output logic [5:0]            led_index,
  output logic [7:0]            green,
  output logic [7:0]            red,
  output logic [7:0]            blue,
  output logic                  frame_last
);

  cfg_t cfg;
  logic [1:0] reg_sel;
  logic cfg_write;
  logic tick;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_valid;
  logic cmd_pop;

  assign pready = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= MODE_RESET;
      cfg.wait_ms <= WAIT_RESET;
      cfg.loop_period <= LOOP_PERIOD_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_MODE:   cfg.mode <= pwdata[1:0];
        REG_WAIT:   cfg.wait_ms <= pwdata[7:0];
        REG_PERIOD: cfg.loop_period <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MODE:   prdata = {30'd0, cfg.mode};
      REG_WAIT:   prdata = {24'd0, cfg.wait_ms};
      REG_PERIOD: prdata = {16'd0, cfg.loop_period};
      default:    prdata = 32'd0;
    endcase
  end

  assign tick = push & ~full;

  rlpg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .tick     (tick),
    .now_ms   (now_ms),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in)
  );

  rlpg_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .valid (cmd_valid),
    .full  (full)
  );

  rlpg_back #(
    .NUM_LEDS (NUM_LEDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd_out),
    .cmd_pop    (cmd_pop),
    .pop        (pop),
    .empty      (empty),
    .led_index  (led_index),
    .green      (green),
    .red        (red),
    .blue       (blue),
    .frame_last (frame_last)
  );

  // A shown beat that carries the highest LED index must be flagged as the frame's last.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (!empty && !frame_last) |-> (led_index != 6'(NUM_LEDS - 1)))
    else $error("non-final beat carries the last LED index");

  // Inside a frame the beat after a taken one is the next LED.
  a_index_seq: assert property (@(posedge clk) disable iff (rst)
    ($past(pop) && !$past(empty) && !$past(frame_last) && !empty) |->
      (led_index == 6'($past(led_index) + 6'd1)))
    else $error("LED index skipped inside a frame");

  // While in single-LED mode every shown beat is flagged as the last of its frame.
  a_single_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !frame_last) |-> (cfg.mode != MODE_SINGLE))
    else $error("unfinished frame while in single LED mode");

endmodule

// ----- dv/tb_rainbow_led_pattern_generator.sv -----
`timescale 1ns / 1ps

module tb_rainbow_led_pattern_generator;
  import rlpg_pkg::*;

  localparam int LED_COUNT = NUM_LEDS_DEFAULT;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT = 4000;
  localparam int REPORT_MAX = 10;

  typedef struct {
    logic [5:0] idx;
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] b;
    logic       last;
  } led_beat_t;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } color_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic [31:0] now_ms = '0;
  logic empty;
  logic pop = 1'b0;
  logic [5:0] led_index;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] blue;
  logic frame_last;

  // Shadow copy of the registers and of the pattern state.
  logic [1:0] cfg_mode = MODE_RESET;
  logic [7:0] cfg_wait = WAIT_RESET;
  logic [15:0] cfg_period = LOOP_PERIOD_RESET;
  logic [31:0] time_mark = '0;
  logic [7:0] hue = '0;
  logic [8:0] tick_count = '0;

  led_beat_t expected_leds[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fault_count = 0;
  int stall_cycles = 0;
  logic [31:0] cur_time = '0;

  rainbow_led_pattern_generator u_top (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .push      (push),
    .full      (full),
    .now_ms    (now_ms),
    .empty     (empty),
    .pop       (pop),
    .led_index (led_index),
    .green     (green),
    .red       (red),
    .blue      (blue),
    .frame_last(frame_last)
  );

  always #6 clk = ~clk;

  function automatic color_t wheel_rgb(input logic [7:0] pos);
    int p;
    color_t c;
    p = 255 - int'(pos);
    if (p < 85) begin
      c.r = 8'(255 - 3 * p);
      c.g = 8'd0;
      c.b = 8'(3 * p);
    end else if (p < 170) begin
      p = p - 85;
      c.r = 8'd0;
      c.g = 8'(3 * p);
      c.b = 8'(255 - 3 * p);
    end else begin
      p = p - 170;
      c.r = 8'(3 * p);
      c.g = 8'(255 - 3 * p);
      c.b = 8'd0;
    end
    return c;
  endfunction

  function automatic void queue_led(input int idx, input logic [7:0] pos, input logic last);
    led_beat_t beat;
    color_t c;
    c = wheel_rgb(pos);
    beat.idx = 6'(idx);
    beat.g = c.g;
    beat.r = c.r;
    beat.b = c.b;
    beat.last = last;
    expected_leds.push_back(beat);
  endfunction

  // Advances the pattern state for one tick and queues the LED colors it produces.
  function automatic void advance_pattern(input logic [31:0] now);
    logic [31:0] span;
    span = now - time_mark;
    case (cfg_mode)
      MODE_INTERVAL: begin
        if (span >= 32'(cfg_wait)) begin
          time_mark = now;
          hue = hue + 8'd1;
          for (int i = 0; i < LED_COUNT; i++)
            queue_led(i, 8'(i + int'(hue)), i == LED_COUNT - 1);
        end
      end
      MODE_DEADLINE: begin
        if (now > time_mark) begin
          hue = hue + 8'd1;
          time_mark = now + 32'(cfg_wait);
          for (int i = 0; i < LED_COUNT; i++)
            queue_led(i, 8'((i * 256) / LED_COUNT + int'(hue)), i == LED_COUNT - 1);
        end
      end
      MODE_SINGLE: begin
        tick_count = tick_count + 9'd1;
        if (32'(tick_count) * 256 >= 32'(cfg_period)) begin
          tick_count = '0;
          hue = hue + 8'd1;
          queue_led(0, hue, 1'b1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void note_fault(input string what);
    if (fault_count < REPORT_MAX)
      $display("%t: %s", $realtime, what);
    fault_count++;
  endfunction

  task automatic check_led_beat();
    led_beat_t want;
    if (expected_leds.size() == 0) begin
      note_fault($sformatf("unexpected beat: led %0d g %02x r %02x b %02x last %0b",
                           led_index, green, red, blue, frame_last));
      return;
    end
    want = expected_leds.pop_front();
    if (led_index !== want.idx || green !== want.g || red !== want.r || blue !== want.b ||
        frame_last !== want.last)
      note_fault($sformatf({"led beat mismatch: expected led %0d g %02x r %02x b %02x last %0b,",
                            " got led %0d g %02x r %02x b %02x last %0b"},
                           want.idx, want.g, want.r, want.b, want.last,
                           led_index, green, red, blue, frame_last));
  endtask

  // Result side: check each accepted beat, then decide whether to pop next cycle.
  always @(posedge clk) begin
    if (!rst && pop && !empty)
      check_led_beat();
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_rainbow_led_pattern_generator: done, errors");
        $finish;
      end
    end
  end

  task automatic send_tick(input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    now_ms <= value;
    do @(posedge clk); while (full);
    advance_pattern(value);
    cur_time = value;
  endtask

  // Holds the sender until every queued color has been delivered and the block has settled.
  task automatic drain();
    push <= 1'b0;
    while (expected_leds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MODE: cfg_mode = value[1:0];
      REG_WAIT: cfg_wait = value[7:0];
      REG_PERIOD: cfg_period = value[15:0];
      default: begin
      end
    endcase
  endtask

  task automatic test_interval();
    // Reset settings: interval mode, 20 ms wait.
    send_tick(32'd0);
    send_tick(32'd19);
    send_tick(32'd20);
    send_tick(32'd39);
    send_tick(32'd40);
    send_tick(32'hffff_ffff);
    // The difference wraps past zero and still counts as elapsed time.
    send_tick(32'h0000_0013);
    cfg_write(REG_WAIT, 32'd0);
    send_tick(32'h0000_0013);
    send_tick(32'h0000_0013);
    cfg_write(REG_WAIT, 32'd255);
    send_tick(32'h0000_0113);
    send_tick(32'h0000_0211);
  endtask

  task automatic test_deadline();
    cfg_write(REG_MODE, 32'(MODE_DEADLINE));
    // This deadline wraps past the top of the time range and is met once the time passes the wrapped value.
    send_tick(32'hffff_ff80);
    send_tick(32'h0000_007f);
    send_tick(32'h0000_0080);
    cfg_write(REG_WAIT, 32'd0);
    send_tick(32'h0000_0180);
    send_tick(32'h0000_0180);
    send_tick(32'h0000_0181);
  endtask

  task automatic test_single_led();
    cfg_write(REG_MODE, 32'(MODE_SINGLE));
    cfg_write(REG_PERIOD, 32'd0);
    repeat (2) send_tick($urandom);
    cfg_write(REG_PERIOD, 32'd257);
    repeat (3) send_tick($urandom);
    cfg_write(REG_PERIOD, 32'd1000);
    repeat (4) send_tick($urandom);
  endtask

  task automatic test_mode_three();
    cfg_write(REG_MODE, 32'(MODE_UNUSED));
    repeat (3) send_tick($urandom);
    cfg_write(REG_MODE, 32'(MODE_INTERVAL));
    cfg_write(REG_WAIT, 32'd20);
    send_tick(cur_time + 32'd20);
  endtask

  task automatic test_slow_loop();
    cfg_write(REG_MODE, 32'(MODE_SINGLE));
    cfg_write(REG_PERIOD, 32'd65535);
    repeat (257) send_tick($urandom);
  endtask

  task automatic test_random_mix(input int phases, input int ticks);
    int pick;
    logic [31:0] value;
    for (int ph = 0; ph < phases; ph++) begin
      pick = $urandom_range(0, 9);
      cfg_write(REG_MODE, 32'(pick < 3 ? MODE_INTERVAL : pick < 6 ? MODE_DEADLINE :
                              pick < 9 ? MODE_SINGLE : MODE_UNUSED));
      pick = $urandom_range(0, 9);
      cfg_write(REG_WAIT, pick == 0 ? 32'd0 : pick == 1 ? 32'd255 : $urandom_range(1, 254));
      pick = $urandom_range(0, 9);
      cfg_write(REG_PERIOD, pick == 0 ? 32'd0 : pick == 1 ? 32'd65535 : $urandom_range(1, 3000));
      // Start just short of the current mark so that updates come soon in either timed mode.
      cur_time = time_mark - 32'($urandom_range(0, 8));
      for (int k = 0; k < ticks; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4)
          value = $urandom;
        else if (pick < 10)
          value = cur_time - 32'($urandom_range(0, 300));
        else
          value = cur_time + 32'($urandom_range(0, 2 * int'(cfg_wait) + 2));
        send_tick(value);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 37;
    recv_idle_pct = 85;
    test_interval();
    test_deadline();
    test_single_led();
    test_mode_three();
    test_random_mix(2, 21);
    send_idle_pct = 85;
    recv_idle_pct = 37;
    test_slow_loop();
    test_random_mix(2, 21);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(2, 21);
    drain();
    if (fault_count == 0) begin
      $display("tb_rainbow_led_pattern_generator: done, clean");
    end else begin
      $display("tb_rainbow_led_pattern_generator: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/rlpg_pkg.sv
hw/rtl/rlpg_front.sv
hw/rtl/rlpg_cmd_fifo.sv
hw/rtl/rlpg_back.sv
hw/rtl/rainbow_led_pattern_generator.sv
dv/tb_rainbow_led_pattern_generator.sv
